// ----- src/catmull_rom_curve_tessellator_core_assert.svh -----
// ----------------------------------------------------------------------------
// Catmull-Rom tessellator assertion macros
// Shorthand for clocked implications with reset disable.
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_CURVE_TESSELLATOR_CORE_ASSERT_SVH
`define CATMULL_ROM_CURVE_TESSELLATOR_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CRCT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define CRCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/crct_pkg.sv -----
// ----------------------------------------------------------------------------
// crct_pkg
// Types, constants and helpers shared by the Catmull-Rom tessellator.
// ----------------------------------------------------------------------------
package crct_pkg;

	localparam int COORD_W          = 32;
	localparam int QUOT_BITS        = COORD_W - 1;
	localparam int COEF_W           = 36;
	localparam int DEFAULT_SEGMENTS = 8;

	localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vec_t;

	typedef struct packed {
		coord_t a;
		coord_t b;
		coord_t c;
		coord_t d;
	} span_op_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t point_z;
		logic   final_point;
	} point_t;

	typedef struct packed {
		coord_t sample_x;
		coord_t sample_y;
		coord_t sample_z;
		logic   run_end;
		logic   curve_end;
	} sample_t;

	function automatic coord_t vec_coord(input vec_t v, input logic [1:0] axis);
		coord_t r;
		case (axis)
			AXIS_X:  r = v.x;
			AXIS_Y:  r = v.y;
			default: r = v.z;
		endcase
		return r;
	endfunction

endpackage

// ----- src/catmull_rom_curve_tessellator_core.sv -----
// ----------------------------------------------------------------------------
// catmull_rom_curve_tessellator_core
// Streaming uniform Catmull-Rom tessellator for 3D control points in Q16.16.
// ----------------------------------------------------------------------------
// Control points enter one transaction at a time; each point from the third
// on emits SEGMENTS samples of the span two points back, and a point flagged
// final_point also emits the closing span and the point itself (a two-point
// curve emits its two points, a one-point curve nothing). Points that emit
// nothing leave the sequencer idle, so point_stall stays low. Every span
// sample runs its three coordinates one after another through a single
// shared unit, in this order: launch, four multiply-accumulate steps,
// rounding, a three-step reciprocal multiply (at SEGMENTS = 8) that divides
// by 2*SEGMENTS^3, handoff; a saturated coordinate skips the multiply. The
// output write of each sample waits while sample_stall holds the output
// register. Plain point outputs bypass the shared unit. point_stall stays
// high until the last result of a point is in the output register; that
// register holds a result while the next one is computed.
// ----------------------------------------------------------------------------
`include "catmull_rom_curve_tessellator_core_assert.svh"

module catmull_rom_curve_tessellator_core
	import crct_pkg::*;
#(
	parameter int SEGMENTS = DEFAULT_SEGMENTS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    point_valid,
	output logic    point_stall,
	input  point_t  point,
	output logic    sample_valid,
	input  logic    sample_stall,
	output sample_t sample
);

	localparam int STEP_W = $clog2(SEGMENTS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SEGMENTS - 1);
	localparam logic [1:0] SEEN_FULL = 2'd3;
	localparam logic [1:0] SEEN_ONE  = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_WAIT,
		ST_EMIT_SPAN,
		ST_EMIT_POINT
	} state_t;

	state_t            state_q;
	vec_t              win_q [3];
	logic [1:0]        seen_q;
	vec_t              pa_q, pb_q, pc_q, pd_q;
	logic              fin_q;
	logic [1:0]        spans_q;
	logic [1:0]        points_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        axis_q;
	vec_t              res_q;
	sample_t           sample_q;
	logic              sample_valid_q;

	logic     point_accept;
	logic     out_free;
	logic     emit;
	logic     span_last;
	vec_t     cur;
	span_op_t op;
	logic     u_start;
	logic     u_done;
	coord_t   u_value;

	assign point_stall  = (state_q != ST_IDLE);
	assign point_accept = point_valid && !point_stall;
	assign out_free     = !sample_valid_q || !sample_stall;
	assign emit         = out_free && ((state_q == ST_EMIT_SPAN) || (state_q == ST_EMIT_POINT));
	assign span_last    = (step_q == STEP_LAST) && (spans_q == 2'd1) && (points_q == 2'd0);
	assign u_start      = (state_q == ST_CALC);

	always_comb begin
		cur.x = point.point_x;
		cur.y = point.point_y;
		cur.z = point.point_z;
		op.a  = vec_coord(pa_q, axis_q);
		op.b  = vec_coord(pb_q, axis_q);
		op.c  = vec_coord(pc_q, axis_q);
		op.d  = vec_coord(pd_q, axis_q);
	end

	crct_sample_unit #(
		.SEGMENTS(SEGMENTS)
	) u_sample (
		.clk   (clk),
		.arst_n(arst_n),
		.start (u_start),
		.op    (op),
		.step  (step_q),
		.done  (u_done),
		.value (u_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			win_q[0]       <= '0;
			win_q[1]       <= '0;
			win_q[2]       <= '0;
			seen_q         <= '0;
			pa_q           <= '0;
			pb_q           <= '0;
			pc_q           <= '0;
			pd_q           <= '0;
			fin_q          <= 1'b0;
			spans_q        <= '0;
			points_q       <= '0;
			step_q         <= '0;
			axis_q         <= AXIS_X;
			res_q          <= '0;
			sample_q       <= '0;
			sample_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				sample_valid_q <= 1'b1;
			end else if (sample_valid_q && !sample_stall) begin
				sample_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (point_accept) begin
						fin_q  <= point.final_point;
						step_q <= '0;
						axis_q <= AXIS_X;
						pa_q   <= (seen_q == SEEN_FULL) ? win_q[2] : win_q[1];
						pb_q   <= seen_q[1] ? win_q[1] : win_q[0];
						pc_q   <= seen_q[1] ? win_q[0] : cur;
						pd_q   <= cur;
						if (point.final_point) begin
							spans_q  <= seen_q[1] ? 2'd2 : 2'd0;
							points_q <= seen_q[1] ? 2'd1 :
								((seen_q == SEEN_ONE) ? 2'd2 : 2'd0);
							seen_q   <= '0;
						end else begin
							spans_q  <= seen_q[1] ? 2'd1 : 2'd0;
							points_q <= 2'd0;
							win_q[2] <= win_q[1];
							win_q[1] <= win_q[0];
							win_q[0] <= cur;
							seen_q   <= (seen_q == SEEN_FULL) ? SEEN_FULL : seen_q + 2'd1;
						end
						if (seen_q[1]) begin
							state_q <= ST_CALC;
						end else if (point.final_point && seen_q == SEEN_ONE) begin
							state_q <= ST_EMIT_POINT;
						end
					end
				end
				ST_CALC: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (u_done) begin
						case (axis_q)
							AXIS_X:  res_q.x <= u_value;
							AXIS_Y:  res_q.y <= u_value;
							default: res_q.z <= u_value;
						endcase
						if (axis_q == AXIS_Z) begin
							state_q <= ST_EMIT_SPAN;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= ST_CALC;
						end
					end
				end
				ST_EMIT_SPAN: begin
					if (out_free) begin
						sample_q.sample_x  <= res_q.x;
						sample_q.sample_y  <= res_q.y;
						sample_q.sample_z  <= res_q.z;
						sample_q.run_end   <= span_last;
						sample_q.curve_end <= span_last && fin_q;
						axis_q             <= AXIS_X;
						if (step_q == STEP_LAST) begin
							step_q  <= '0;
							spans_q <= spans_q - 2'd1;
							pa_q    <= pb_q;
							pb_q    <= pc_q;
							pc_q    <= pd_q;
							if (spans_q != 2'd1) begin
								state_q <= ST_CALC;
							end else if (points_q != 2'd0) begin
								state_q <= ST_EMIT_POINT;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							step_q  <= step_q + STEP_W'(1);
							state_q <= ST_CALC;
						end
					end
				end
				ST_EMIT_POINT: begin
					if (out_free) begin
						sample_q.sample_x  <= pb_q.x;
						sample_q.sample_y  <= pb_q.y;
						sample_q.sample_z  <= pb_q.z;
						sample_q.run_end   <= (points_q == 2'd1);
						sample_q.curve_end <= (points_q == 2'd1) && fin_q;
						pa_q               <= pb_q;
						pb_q               <= pc_q;
						pc_q               <= pd_q;
						points_q           <= points_q - 2'd1;
						if (points_q == 2'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample_valid = sample_valid_q;
	assign sample       = sample_q;

	`CRCT_ASSERT_SAME(a_done_in_wait, clk, arst_n, u_done, state_q == ST_WAIT,
		"sample unit finished outside the wait state")
	`CRCT_ASSERT_NEXT(a_final_clears_count, clk, arst_n,
		point_accept && point.final_point, seen_q == 2'd0,
		"point count not cleared after the final point")
	`CRCT_ASSERT_SAME(a_curve_end_is_run_end, clk, arst_n,
		sample_valid && sample.curve_end, sample.run_end,
		"curve end flagged on a result that does not end its run")
	`CRCT_ASSERT_NEXT(a_idle_after_run_end, clk, arst_n,
		state_q == ST_EMIT_POINT && out_free && points_q == 2'd1, state_q == ST_IDLE,
		"sequencer busy after the last point transaction")

endmodule

// ----- src/crct_sample_unit.sv -----
// ----------------------------------------------------------------------------
// crct_sample_unit
// One coordinate of one curve sample: a shared multiply-accumulate over the
// four cubic terms, then round-to-nearest by a reciprocal multiplication in
// 16-bit slices, with saturation to signed 32 bits.
// ----------------------------------------------------------------------------
module crct_sample_unit
	import crct_pkg::*;
#(
	parameter int SEGMENTS = DEFAULT_SEGMENTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  span_op_t                     op,
	input  logic [$clog2(SEGMENTS)-1:0]  step,
	output logic                         done,
	output coord_t                       value
);

	localparam int STEP_W      = $clog2(SEGMENTS);
	localparam int DEN         = 2 * SEGMENTS * SEGMENTS * SEGMENTS;
	localparam int HALF_DEN    = DEN / 2;
	localparam int WEIGHT_W    = $clog2(DEN + 1);
	localparam int ACC_W       = COEF_W + WEIGHT_W + 1;
	localparam int DEN_LOG     = $clog2(DEN);
	localparam int X_W         = QUOT_BITS + DEN_LOG;
	localparam int RECIP_SHIFT = X_W + DEN_LOG;
	localparam int CHUNK_W     = 16;
	localparam int CHUNKS      = (DEN_LOG + 33 + CHUNK_W - 1) / CHUNK_W;
	localparam int CHUNK_CNT_W = $clog2(CHUNKS);
	localparam int RECIP_PAD   = CHUNKS * CHUNK_W;
	localparam int PART_W      = X_W + CHUNK_W;
	localparam int DIV_W       = X_W + RECIP_PAD;
	localparam logic [63:0] RECIP =
		((64'd1 << RECIP_SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
	localparam logic [RECIP_PAD-1:0]   RECIP_BITS  = RECIP[RECIP_PAD-1:0];
	localparam logic [CHUNK_CNT_W-1:0] CHUNK_FIRST = CHUNK_CNT_W'(CHUNKS - 1);
	localparam logic [1:0]             TERM_LAST   = 2'd3;

	typedef enum logic [1:0] {U_IDLE, U_MAC, U_ROUND, U_DIV} ustate_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	ustate_t                 state_q;
	coef_t                   coef_q [4];
	logic [1:0]              term_q;
	logic [STEP_W-1:0]       step_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    neg_q;
	logic [X_W-1:0]          x_q;
	logic [DIV_W-1:0]        div_acc_q;
	logic [CHUNK_CNT_W-1:0]  chunk_q;
	logic                    done_q;
	logic [COORD_W-1:0]      value_q;

	logic [WEIGHT_W-1:0]     weight [4][SEGMENTS];
	logic [CHUNK_W-1:0]      recip_part [CHUNKS];

	for (genvar g = 0; g < SEGMENTS; g++) begin : g_weight
		assign weight[0][g] = WEIGHT_W'(DEN);
		assign weight[1][g] = WEIGHT_W'(SEGMENTS * SEGMENTS * g);
		assign weight[2][g] = WEIGHT_W'(SEGMENTS * g * g);
		assign weight[3][g] = WEIGHT_W'(g * g * g);
	end

	for (genvar g = 0; g < CHUNKS; g++) begin : g_recip
		assign recip_part[g] = RECIP_BITS[g*CHUNK_W +: CHUNK_W];
	end

	coef_t                   ea, eb, ec, ed;
	coef_t                   c1, c2, c3;
	logic signed [ACC_W-1:0] prod;
	logic [ACC_W-1:0]        mag;
	logic [ACC_W-1:0]        rnd;
	logic                    sat;
	logic [PART_W-1:0]       part;
	logic [DIV_W-1:0]        div_next;
	logic [COORD_W-1:0]      quot_ext;

	always_comb begin
		ea = COEF_W'(op.a);
		eb = COEF_W'(op.b);
		ec = COEF_W'(op.c);
		ed = COEF_W'(op.d);
		c1 = ec - ea;
		c2 = (ea <<< 1) - ((eb <<< 2) + eb) + (ec <<< 2) - ed;
		c3 = ((eb <<< 1) + eb) - ((ec <<< 1) + ec) + ed - ea;

		prod = ACC_W'(coef_q[term_q]) * ACC_W'($signed({1'b0, weight[term_q][step_q]}));

		mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		rnd = mag + ACC_W'(HALF_DEN);
		sat = rnd[ACC_W-1:QUOT_BITS] >= (ACC_W - QUOT_BITS)'(DEN);

		part     = PART_W'(x_q) * PART_W'(recip_part[chunk_q]);
		div_next = (div_acc_q << CHUNK_W) + DIV_W'(part);
		quot_ext = {1'b0, div_next[RECIP_SHIFT +: QUOT_BITS]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= U_IDLE;
			done_q    <= 1'b0;
			coef_q    <= '{default: '0};
			term_q    <= '0;
			step_q    <= '0;
			acc_q     <= '0;
			neg_q     <= 1'b0;
			x_q       <= '0;
			div_acc_q <= '0;
			chunk_q   <= '0;
			value_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: begin
					if (start) begin
						coef_q[0] <= eb;
						coef_q[1] <= c1;
						coef_q[2] <= c2;
						coef_q[3] <= c3;
						step_q    <= step;
						term_q    <= '0;
						acc_q     <= '0;
						state_q   <= U_MAC;
					end
				end
				U_MAC: begin
					acc_q  <= acc_q + prod;
					term_q <= term_q + 2'd1;
					if (term_q == TERM_LAST) begin
						state_q <= U_ROUND;
					end
				end
				U_ROUND: begin
					neg_q <= acc_q[ACC_W-1];
					if (sat) begin
						value_q <= acc_q[ACC_W-1] ? COORD_MIN : COORD_MAX;
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end else begin
						x_q       <= rnd[X_W-1:0];
						div_acc_q <= '0;
						chunk_q   <= CHUNK_FIRST;
						state_q   <= U_DIV;
					end
				end
				U_DIV: begin
					div_acc_q <= div_next;
					chunk_q   <= chunk_q - CHUNK_CNT_W'(1);
					if (chunk_q == '0) begin
						value_q <= neg_q ? -quot_ext : quot_ext;
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign value = coord_t'(value_q);

endmodule
